>>> rtl/rgb_to_hsv_byte_defines.svh
// shared assertion macros for the hsv converter
`ifndef RGB_TO_HSV_BYTE_DEFINES_SVH
`define RGB_TO_HSV_BYTE_DEFINES_SVH

// checked only out of reset
`define RTHSV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every edge, reset included
`define RTHSV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/rthsv_pkg.sv
package rthsv_pkg;

  localparam int unsigned PixW     = 8;
  localparam int unsigned QuoW     = 8;
  localparam int unsigned DivSteps = QuoW;
  localparam int unsigned DvdW     = 16;

  localparam logic [PixW-1:0] HueStep     = 8'd43;
  localparam logic [PixW-1:0] SectorRed   = 8'd0;
  localparam logic [PixW-1:0] SectorGreen = 8'd85;
  localparam logic [PixW-1:0] SectorBlue  = 8'd171;

  // per-pixel data that rides alongside the dividers
  typedef struct packed {
    logic [PixW-1:0] hi;
    logic [PixW-1:0] offset;
    logic            neg;
    logic            gray;
  } side_t;

endpackage

>>> rtl/rthsv_intf.sv
interface rthsv_rgb_if import rthsv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] red;
  logic [PixW-1:0] green;
  logic [PixW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rthsv_hsv_if import rthsv_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [PixW-1:0] hue;
  logic [PixW-1:0] saturation;
  logic [PixW-1:0] brightness_value;

  modport source (output valid, output hue, output saturation, output brightness_value,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input brightness_value,
                  output ready);
endinterface

>>> rtl/rthsv_div.sv
module rthsv_div import rthsv_pkg::*; (
  input  logic                clk_i,
  input  logic [DivSteps-1:0] en_i,
  input  logic [DvdW-1:0]     dividend_i,
  input  logic [PixW-1:0]     divisor_i,
  output logic [QuoW-1:0]     quotient_o
);

  // restoring division, one quotient bit per stage, msb first
  logic [DvdW-1:0] rem_q [DivSteps];
  logic [PixW-1:0] dvs_q [DivSteps];
  logic [QuoW-1:0] quo_q [DivSteps];

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    localparam int unsigned Shift = QuoW - 1 - k;

    logic [DvdW-1:0] rem_in;
    logic [PixW-1:0] dvs_in;
    logic [QuoW-1:0] quo_in;
    logic [DvdW:0]   trial;
    logic [DvdW-1:0] rem_d;
    logic [QuoW-1:0] quo_d;

    if (k == 0) begin : g_first
      assign rem_in = dividend_i;
      assign dvs_in = divisor_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign dvs_in = dvs_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      trial = {1'b0, rem_in} - ({{(DvdW + 1 - PixW){1'b0}}, dvs_in} << Shift);
      quo_d = quo_in;
      if (!trial[DvdW]) begin
        rem_d        = trial[DvdW-1:0];
        quo_d[Shift] = 1'b1;
      end else begin
        rem_d = rem_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        rem_q[k] <= rem_d;
        dvs_q[k] <= dvs_in;
        quo_q[k] <= quo_d;
      end
    end
  end

  assign quotient_o = quo_q[DivSteps-1];

endmodule

>>> rtl/rgb_to_hsv_byte.sv
// RGB to HSV pixel converter, 8 bits per channel. Takes one pixel per clock and gives one
// HSV result per pixel, in order, after 11 register stages (input decode, constant scaling,
// eight steps of a restoring divider, output). Throughput is one pixel per cycle when the
// sink keeps ready high; a full stage holds only while the one after it cannot take its
// content, so a stall on the output fills the bubbles before it backs up to pix_i.ready.
// Saturation and hue each use their own eight-stage divider, which sets the latency. Hue
// runs 0 to 255 with red at 0, green at 85 and blue at 171; gray pixels give hue 0 and
// saturation 0.
`include "rgb_to_hsv_byte_defines.svh"

module rgb_to_hsv_byte import rthsv_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rthsv_rgb_if.sink    pix_i,
  rthsv_hsv_if.source  hsv_o
);

  localparam int unsigned NumStages = DivSteps + 3;
  localparam int unsigned Last      = NumStages - 1;

  logic [NumStages-1:0] valid_q;
  logic [NumStages-1:0] en;

  // a stage takes new data when empty or when its content moves on
  always_comb begin
    en[Last] = !valid_q[Last] || hsv_o.ready;
    for (int k = Last - 1; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign pix_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) valid_q[0] <= pix_i.valid;
      for (int k = 1; k < NumStages; k++) begin
        if (en[k]) valid_q[k] <= valid_q[k-1];
      end
    end
  end

  // stage a: max, min, sector and signed channel difference
  logic            r_ge_g, r_ge_b, g_ge_b;
  logic [PixW-1:0] hi_d, lo_d, pos_d, negv_d, off_d;
  logic [PixW-1:0] hi_a_q, chroma_a_q, diff_a_q, off_a_q;
  logic            neg_a_q;

  always_comb begin
    r_ge_g = pix_i.red >= pix_i.green;
    r_ge_b = pix_i.red >= pix_i.blue;
    g_ge_b = pix_i.green >= pix_i.blue;
    if (r_ge_g && r_ge_b) begin
      hi_d   = pix_i.red;
      off_d  = SectorRed;
      pos_d  = pix_i.green;
      negv_d = pix_i.blue;
    end else if (g_ge_b) begin
      hi_d   = pix_i.green;
      off_d  = SectorGreen;
      pos_d  = pix_i.blue;
      negv_d = pix_i.red;
    end else begin
      hi_d   = pix_i.blue;
      off_d  = SectorBlue;
      pos_d  = pix_i.red;
      negv_d = pix_i.green;
    end
    if (!r_ge_g && !r_ge_b)    lo_d = pix_i.red;
    else if (r_ge_g && !g_ge_b) lo_d = pix_i.green;
    else                        lo_d = pix_i.blue;
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      hi_a_q     <= hi_d;
      chroma_a_q <= hi_d - lo_d;
      off_a_q    <= off_d;
      neg_a_q    <= pos_d < negv_d;
      diff_a_q   <= (pos_d < negv_d) ? negv_d - pos_d : pos_d - negv_d;
    end
  end

  // stage b: scale numerators by the constants
  logic [DvdW-1:0] sat_dvd_b_q, hue_dvd_b_q;
  logic [PixW-1:0] dvs_b_q;
  side_t           side_b_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sat_dvd_b_q   <= {chroma_a_q, {(DvdW - PixW){1'b0}}} - DvdW'(chroma_a_q);
      hue_dvd_b_q   <= DvdW'(diff_a_q) * DvdW'(HueStep);
      dvs_b_q       <= chroma_a_q;
      side_b_q.hi     <= hi_a_q;
      side_b_q.offset <= off_a_q;
      side_b_q.neg    <= neg_a_q;
      side_b_q.gray   <= chroma_a_q == '0;
    end
  end

  // dividers, with the side data delayed to match
  logic [QuoW-1:0] sat_quo, hue_quo;
  side_t           side_q [DivSteps];

  rthsv_div u_sat_div (
    .clk_i      (clk_i),
    .en_i       (en[2 +: DivSteps]),
    .dividend_i (sat_dvd_b_q),
    .divisor_i  (side_b_q.hi),
    .quotient_o (sat_quo)
  );

  rthsv_div u_hue_div (
    .clk_i      (clk_i),
    .en_i       (en[2 +: DivSteps]),
    .dividend_i (hue_dvd_b_q),
    .divisor_i  (dvs_b_q),
    .quotient_o (hue_quo)
  );

  always_ff @(posedge clk_i) begin
    if (en[2]) side_q[0] <= side_b_q;
    for (int k = 1; k < DivSteps; k++) begin
      if (en[k+2]) side_q[k] <= side_q[k-1];
    end
  end

  // output stage: place the magnitude in its sector, wrapping mod 256
  logic [PixW-1:0] hue_q, sat_q, val_q;
  logic [PixW-1:0] hue_d, sat_d;
  side_t           side_last;

  assign side_last = side_q[DivSteps-1];

  always_comb begin
    if (side_last.gray) begin
      hue_d = '0;
      sat_d = '0;
    end else begin
      hue_d = side_last.neg ? side_last.offset - PixW'(hue_quo)
                            : side_last.offset + PixW'(hue_quo);
      sat_d = PixW'(sat_quo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[Last]) begin
      hue_q <= hue_d;
      sat_q <= sat_d;
      val_q <= side_last.hi;
    end
  end

  assign hsv_o.valid            = valid_q[Last];
  assign hsv_o.hue              = hue_q;
  assign hsv_o.saturation       = sat_q;
  assign hsv_o.brightness_value = val_q;

  `RTHSV_ASSERT(a_hue_quo_range,
    valid_q[Last-1] && !side_last.gray |-> hue_quo <= QuoW'(HueStep),
    "hue step out of range")
  `RTHSV_ASSERT(a_sat_zero_gray,
    hsv_o.valid && hsv_o.saturation == '0 |-> hsv_o.hue == '0,
    "zero saturation with non-zero hue")
  `RTHSV_ASSERT(a_out_from_pipe,
    $rose(hsv_o.valid) |-> $past(valid_q[Last-1]),
    "result without an item behind it")
  `RTHSV_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> valid_q == '0, "pipeline not empty in reset")

endmodule
